[sv/bmhq_pkg.sv]
// Shared constants, request codes and transfer structs for the min-heap queue.
package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);      // key store address width
    localparam int CW       = $clog2(CAPACITY + 1);  // fill count width
    localparam int IW       = AW + 2;                // child index width
    localparam int KW       = 32;
    localparam int ECW      = 7;                     // entry_count field width

    localparam logic signed [KW-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY_DEL = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic signed [KW-1:0] key_value;
    } t_req;

    typedef struct packed {
        logic signed [KW-1:0] min_value;
        logic                 is_empty;
        logic [ECW-1:0]       entry_count;
        logic [1:0]           status;
    } t_rsp;

    // result of the shared key compare unit
    typedef struct packed {
        logic                 lt;
        logic signed [KW-1:0] min_key;
    } t_cmp;

endpackage

[sv/binary_min_heap_queue_core.sv]
// Binary min-heap priority queue: key store, sift sequencer and result register.
// Peek, full insert and empty delete set the done flag on the accept; the strobe is registered from it.
// Insert: busy while sifting up, one level per S_UP_CHK/S_UP_CMP pass.
// Delete: busy while sifting down, one level per S_DN_CHK/S_DN_L/S_DN_R/S_DN_MOVE pass.
// The single-read-port key store sets the per-level cost; one item at a time.
// Synchronous active-low reset empties the heap; the receiver cannot stall.
module binary_min_heap_queue_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  bmhq_pkg::t_req   i_req,
    output logic             o_strobe,
    output bmhq_pkg::t_rsp   o_rsp
);
    import bmhq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_MOVE
    } t_state;

    t_state               r_state;
    logic                 r_done;
    logic [CW-1:0]        r_fill;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        r_best;
    logic                 r_mv;
    logic signed [KW-1:0] r_key;
    logic signed [KW-1:0] r_bv;
    logic signed [KW-1:0] r_root;
    logic [1:0]           r_status;
    logic                 r_strobe;
    t_rsp                 r_rsp;

    logic signed [KW-1:0] r_mem [CAPACITY];
    logic signed [KW-1:0] r_rd;

    logic                 w_we;
    logic [AW-1:0]        w_wa;
    logic signed [KW-1:0] w_wd;
    logic [AW-1:0]        w_ra;
    logic signed [KW-1:0] w_ca;
    logic signed [KW-1:0] w_cb;
    t_cmp                 w_cmp;
    logic [IW-1:0]        w_left;
    logic [IW-1:0]        w_right;
    logic [AW-1:0]        w_parent;
    logic                 w_accept;
    logic [CW-1:0]        w_fill_dec;

    assign busy       = (r_state != S_IDLE) || r_done;
    assign w_accept   = start && !busy;
    assign w_left     = {1'b0, r_pos, 1'b1};
    assign w_right    = w_left + IW'(1);
    assign w_parent   = AW'((r_pos - AW'(1)) >> 1);
    assign w_fill_dec = r_fill - CW'(1);

    // shared compare unit
    bmhq_cmp u_cmp (
        .i_a   (w_ca),
        .i_b   (w_cb),
        .o_res (w_cmp)
    );

    // compare operand select
    always_comb begin
        unique case (r_state)
            S_UP_CMP: begin
                w_ca = r_key;
                w_cb = r_rd;
            end
            S_DN_R: begin
                w_ca = r_rd;
                w_cb = r_bv;
            end
            default: begin
                w_ca = r_rd;
                w_cb = r_key;
            end
        endcase
    end

    // key store read and write addressing
    always_comb begin
        w_we = 1'b0;
        w_wa = r_pos;
        w_wd = r_key;
        w_ra = r_pos;
        unique case (r_state)
            S_IDLE: begin
                w_ra = w_fill_dec[AW-1:0];
            end
            S_UP_CHK: begin
                w_ra = w_parent;
                if (r_pos == '0) begin
                    w_we = 1'b1;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (w_cmp.lt) begin
                    w_wd = r_rd;
                end
            end
            S_DN_CHK: begin
                w_ra = w_left[AW-1:0];
                if (w_left >= IW'(r_fill)) begin
                    w_we = 1'b1;
                end
            end
            S_DN_L: begin
                w_ra = w_right[AW-1:0];
            end
            S_DN_MOVE: begin
                w_we = 1'b1;
                if (r_mv) begin
                    w_wd = r_bv;
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // key store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    // sequencer, root copy and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_fill   <= '0;
            r_strobe <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_strobe <= 1'b0;
            if (w_we && (w_wa == '0)) begin
                r_root <= w_wd;
            end
            if (r_done) begin
                r_done               <= 1'b0;
                r_strobe             <= 1'b1;
                r_rsp.min_value      <= (r_fill == '0) ? INT_MAX : r_root;
                r_rsp.is_empty       <= (r_fill == '0);
                r_rsp.entry_count    <= ECW'(r_fill);
                r_rsp.status         <= r_status;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_status <= ST_OK;
                        r_key    <= i_req.key_value;
                        r_pos    <= '0;
                        priority if (i_req.req_type == REQ_INSERT) begin
                            if (r_fill >= CW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                                r_done   <= 1'b1;
                            end else begin
                                r_fill  <= r_fill + CW'(1);
                                r_pos   <= r_fill[AW-1:0];
                                r_state <= S_UP_CHK;
                            end
                        end else if (i_req.req_type == REQ_DELETE) begin
                            if (r_fill == '0) begin
                                r_status <= ST_EMPTY_DEL;
                                r_done   <= 1'b1;
                            end else begin
                                r_fill  <= w_fill_dec;
                                r_state <= S_DN_LAST;
                            end
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_UP_CHK: begin
                    if (r_pos == '0) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    if (w_cmp.lt) begin
                        r_pos   <= w_parent;
                        r_state <= S_UP_CHK;
                    end else begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                S_DN_LAST: begin
                    if (r_fill == '0) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_key   <= r_rd;
                        r_state <= S_DN_CHK;
                    end
                end
                S_DN_CHK: begin
                    if (w_left >= IW'(r_fill)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_DN_L;
                    end
                end
                S_DN_L: begin
                    r_bv   <= w_cmp.min_key;
                    r_mv   <= w_cmp.lt;
                    r_best <= w_left[AW-1:0];
                    if (w_right < IW'(r_fill)) begin
                        r_state <= S_DN_R;
                    end else begin
                        r_state <= S_DN_MOVE;
                    end
                end
                S_DN_R: begin
                    if (w_cmp.lt) begin
                        r_bv   <= r_rd;
                        r_mv   <= 1'b1;
                        r_best <= w_right[AW-1:0];
                    end
                    r_state <= S_DN_MOVE;
                end
                S_DN_MOVE: begin
                    if (r_mv) begin
                        r_pos   <= r_best;
                        r_state <= S_DN_CHK;
                    end else begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CW'(w_wa) < r_fill))
        else $error("key store write beyond fill count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted transfer did not raise busy");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.is_empty == (o_rsp.entry_count == '0)))
        else $error("empty flag disagrees with entry count");
`endif

endmodule

[sv/bmhq_cmp.sv]
// Shared signed key compare unit: strict less-than and the smaller key.
module bmhq_cmp (
    input  logic signed [bmhq_pkg::KW-1:0] i_a,
    input  logic signed [bmhq_pkg::KW-1:0] i_b,
    output bmhq_pkg::t_cmp                 o_res
);
    import bmhq_pkg::*;

    // on a tie keep the second operand
    always_comb begin
        o_res.lt      = (i_a < i_b);
        o_res.min_key = o_res.lt ? i_a : i_b;
    end

endmodule
